/* hw/rtl/sidr_pkg.sv */
`default_nettype none

package sidr_pkg;

	localparam int MAX_ENTRIES = 16;
	localparam int ID_BITS     = 8;

	localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
	// common width for position vs count compares
	localparam int CMP_W = 8;

	typedef logic [ID_BITS-1:0] id_t;
	typedef logic [IDX_W-1:0]   idx_t;
	typedef logic [CNT_W-1:0]   cnt_t;
	typedef logic [CMP_W-1:0]   cmp_t;

	localparam logic [1:0] CMD_ADD  = 2'd0;
	localparam logic [1:0] CMD_DEL  = 2'd1;
	localparam logic [1:0] CMD_FIND = 2'd2;
	localparam logic [1:0] CMD_GET  = 2'd3;

	localparam logic [1:0] STAT_OK   = 2'd0;
	localparam logic [1:0] STAT_FULL = 2'd1;
	localparam logic [1:0] STAT_DUP  = 2'd2;
	localparam logic [1:0] STAT_NONE = 2'd3;

	typedef struct packed {
		logic [1:0] command;
		logic [7:0] sid;
		logic [3:0] position;
	} svc_in_t;

	typedef struct packed {
		logic [1:0] status;
		logic [3:0] found_position;
		logic [7:0] found_id;
		logic [4:0] entry_count;
	} svc_out_t;

	typedef struct packed {
		logic we;
		idx_t waddr;
		id_t  wdata;
		idx_t raddr;
	} mem_req_t;

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_GET   = 5'b00010,
		S_SCAN  = 5'b00100,
		S_SHIFT = 5'b01000,
		S_RESP  = 5'b10000
	} state_t;

endpackage

`default_nettype wire

/* hw/rtl/sidr_ram.sv */
`default_nettype none

module sidr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire                                          clk,
	input  wire                                          we,
	input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire [WIDTH-1:0]                              wdata,
	input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                             rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

/* hw/rtl/sidr_seq.sv */
`default_nettype none

module sidr_seq (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     cmd_valid,
	input  wire sidr_pkg::svc_in_t  cmd,
	output logic                    cmd_stall,
	input  wire                     out_free,
	output logic                    res_valid,
	output sidr_pkg::svc_out_t      res,
	output sidr_pkg::mem_req_t      mem_req,
	input  wire sidr_pkg::id_t      mem_rdata
);

	sidr_pkg::state_t state_q;
	logic [1:0]       cmd_q;
	sidr_pkg::id_t    id_q;
	logic [3:0]       pos_q;
	sidr_pkg::cnt_t   count_q;
	sidr_pkg::cnt_t   scan_q;
	logic             rv_s1;
	sidr_pkg::cnt_t   ridx_s1;
	logic [1:0]       res_status_q;
	logic [3:0]       res_pos_q;
	logic [7:0]       res_id_q;

	logic in_fire;
	logic match;
	logic scan_end;
	logic get_hit;

	assign in_fire  = cmd_valid && !cmd_stall;
	assign match    = rv_s1 && (mem_rdata == id_q);
	// nothing in flight and every held entry already read
	assign scan_end = !rv_s1 && (scan_q >= count_q);
	assign get_hit  = sidr_pkg::cmp_t'(pos_q) < sidr_pkg::cmp_t'(count_q);

	assign cmd_stall = (state_q != sidr_pkg::S_IDLE);
	assign res_valid = (state_q == sidr_pkg::S_RESP) && out_free;

	always_comb begin
		res.status         = res_status_q;
		res.found_position = res_pos_q;
		res.found_id       = res_id_q;
		res.entry_count    = 5'(count_q);
	end

	always_comb begin
		mem_req.we    = 1'b0;
		mem_req.waddr = sidr_pkg::idx_t'(count_q);
		mem_req.wdata = id_q;
		mem_req.raddr = sidr_pkg::idx_t'(scan_q);
		case (state_q)
			sidr_pkg::S_GET: begin
				mem_req.raddr = sidr_pkg::idx_t'(pos_q);
			end
			sidr_pkg::S_SCAN: begin
				// append on a missed add
				mem_req.we = !match && scan_end && (cmd_q == sidr_pkg::CMD_ADD);
			end
			sidr_pkg::S_SHIFT: begin
				mem_req.we    = rv_s1;
				mem_req.waddr = sidr_pkg::idx_t'(ridx_s1 - sidr_pkg::cnt_t'(1));
				mem_req.wdata = mem_rdata;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sidr_pkg::S_IDLE;
			count_q <= '0;
			rv_s1   <= 1'b0;
		end else begin
			case (state_q)
				sidr_pkg::S_IDLE: begin
					rv_s1  <= 1'b0;
					scan_q <= '0;
					if (in_fire) begin
						cmd_q <= cmd.command;
						id_q  <= sidr_pkg::id_t'(cmd.sid);
						pos_q <= cmd.position;
						if (cmd.command == sidr_pkg::CMD_GET) begin
							state_q <= sidr_pkg::S_GET;
						end else if (cmd.command == sidr_pkg::CMD_ADD &&
						             count_q >= sidr_pkg::cnt_t'(sidr_pkg::MAX_ENTRIES)) begin
							res_status_q <= sidr_pkg::STAT_FULL;
							res_pos_q    <= '0;
							res_id_q     <= '0;
							state_q      <= sidr_pkg::S_RESP;
						end else begin
							state_q <= sidr_pkg::S_SCAN;
						end
					end
				end
				sidr_pkg::S_GET: begin
					if (rv_s1) begin
						rv_s1        <= 1'b0;
						res_status_q <= sidr_pkg::STAT_OK;
						res_pos_q    <= pos_q;
						res_id_q     <= 8'(mem_rdata);
						state_q      <= sidr_pkg::S_RESP;
					end else if (get_hit) begin
						rv_s1 <= 1'b1;
					end else begin
						res_status_q <= sidr_pkg::STAT_NONE;
						res_pos_q    <= '0;
						res_id_q     <= '0;
						state_q      <= sidr_pkg::S_RESP;
					end
				end
				sidr_pkg::S_SCAN: begin
					if (match) begin
						rv_s1     <= 1'b0;
						res_pos_q <= 4'(ridx_s1);
						res_id_q  <= 8'(id_q);
						case (cmd_q)
							sidr_pkg::CMD_ADD: begin
								res_status_q <= sidr_pkg::STAT_DUP;
								state_q      <= sidr_pkg::S_RESP;
							end
							sidr_pkg::CMD_DEL: begin
								res_status_q <= sidr_pkg::STAT_OK;
								scan_q       <= ridx_s1 + sidr_pkg::cnt_t'(1);
								state_q      <= sidr_pkg::S_SHIFT;
							end
							default: begin
								res_status_q <= sidr_pkg::STAT_OK;
								state_q      <= sidr_pkg::S_RESP;
							end
						endcase
					end else if (scan_end) begin
						if (cmd_q == sidr_pkg::CMD_ADD) begin
							res_status_q <= sidr_pkg::STAT_OK;
							res_pos_q    <= 4'(count_q);
							res_id_q     <= 8'(id_q);
							count_q      <= count_q + sidr_pkg::cnt_t'(1);
						end else begin
							res_status_q <= sidr_pkg::STAT_NONE;
							res_pos_q    <= '0;
							res_id_q     <= '0;
						end
						state_q <= sidr_pkg::S_RESP;
					end else if (scan_q < count_q) begin
						rv_s1   <= 1'b1;
						ridx_s1 <= scan_q;
						scan_q  <= scan_q + sidr_pkg::cnt_t'(1);
					end else begin
						rv_s1 <= 1'b0;
					end
				end
				sidr_pkg::S_SHIFT: begin
					// read entry j+1 while entry j-1 is written back
					if (scan_q < count_q) begin
						rv_s1   <= 1'b1;
						ridx_s1 <= scan_q;
						scan_q  <= scan_q + sidr_pkg::cnt_t'(1);
					end else begin
						rv_s1 <= 1'b0;
						if (!rv_s1) begin
							count_q <= count_q - sidr_pkg::cnt_t'(1);
							state_q <= sidr_pkg::S_RESP;
						end
					end
				end
				sidr_pkg::S_RESP: begin
					if (out_free) begin
						state_q <= sidr_pkg::S_IDLE;
					end
				end
				default: begin
					state_q <= sidr_pkg::S_IDLE;
				end
			endcase
		end
	end

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= sidr_pkg::cnt_t'(sidr_pkg::MAX_ENTRIES))
		else $error("entry count above table size");

	a_write_states: assert property (@(posedge clk) disable iff (!arst_n)
		mem_req.we |-> (state_q == sidr_pkg::S_SCAN || state_q == sidr_pkg::S_SHIFT))
		else $error("table write outside scan or shift");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> (state_q != sidr_pkg::S_IDLE))
		else $error("accepted beat left sequencer idle");

	a_resp_once: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |=> (state_q == sidr_pkg::S_IDLE))
		else $error("result issued twice");

	a_shift_below_count: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_req.we && state_q == sidr_pkg::S_SHIFT) |->
			(sidr_pkg::cnt_t'(mem_req.waddr) < count_q))
		else $error("shift write beyond held entries");

endmodule

`default_nettype wire

/* hw/rtl/service_id_registry_unit.sv */
// channel | direction | handshake            | payload
// cmd     | in        | cmd_valid, cmd_stall | sidr_pkg::svc_in_t
// rsp     | out       | rsp_valid, rsp_stall | sidr_pkg::svc_out_t
//
// a get reads one table entry and an add to a full table reads none;
// add and find scan the held entries, and delete scans up to the match and then shifts
// the rest down, both at one read per cycle over the table memory
// one command in flight; a result waits in the output register while the next beat is taken
// reset clears the count but not the table, so the table needs no clearing pass
// rsp_stall holds the output register and, once the sequencer finishes, stalls cmd

`default_nettype none

module service_id_registry_unit (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     cmd_valid,
	output logic                    cmd_stall,
	input  wire sidr_pkg::svc_in_t  cmd,
	output logic                    rsp_valid,
	input  wire                     rsp_stall,
	output sidr_pkg::svc_out_t      rsp
);

	sidr_pkg::mem_req_t mem_req;
	sidr_pkg::id_t      mem_rdata;
	sidr_pkg::svc_out_t res;
	logic               res_valid;
	logic               out_free;
	logic               rsp_valid_q;
	sidr_pkg::svc_out_t rsp_q;

	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	sidr_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_stall (cmd_stall),
		.out_free  (out_free),
		.res_valid (res_valid),
		.res       (res),
		.mem_req   (mem_req),
		.mem_rdata (mem_rdata)
	);

	sidr_ram #(
		.WIDTH (sidr_pkg::ID_BITS),
		.DEPTH (sidr_pkg::MAX_ENTRIES)
	) u_table (
		.clk   (clk),
		.we    (mem_req.we),
		.waddr (mem_req.waddr),
		.wdata (mem_req.wdata),
		.raddr (mem_req.raddr),
		.rdata (mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_valid) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			rsp_q <= res;
		end
	end

endmodule

`default_nettype wire

/* bench/service_id_registry_unit_test.sv */
module service_id_registry_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 400000;
	localparam int DIRECTED_COUNT = 25;
	localparam int RANDOM_COUNT = 1425;
	localparam int QUIET_FROM = 1300;
	localparam int POOL_SIZE = 24;

	typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} mix_t;

	class registry_tracker;
		sidr_pkg::id_t held_ids [sidr_pkg::MAX_ENTRIES];
		int held;
		sidr_pkg::svc_out_t pending_answers [$];
		int failures;

		// what the registry should answer, updating the tracked table on the way
		function sidr_pkg::svc_out_t registry_answer(sidr_pkg::svc_in_t c);
			sidr_pkg::svc_out_t r;
			sidr_pkg::id_t id;
			int k;
			r = '0;
			r.status = sidr_pkg::STAT_NONE;
			id = c.sid[sidr_pkg::ID_BITS-1:0];
			k = -1;
			for (int i = 0; i < held; i++) begin
				if (k < 0 && held_ids[i] == id)
					k = i;
			end
			case (c.command)
				sidr_pkg::CMD_ADD: begin
					if (held >= sidr_pkg::MAX_ENTRIES) begin
						r.status = sidr_pkg::STAT_FULL;
					end else if (k >= 0) begin
						r.status = sidr_pkg::STAT_DUP;
						r.found_position = k[3:0];
						r.found_id = 8'(id);
					end else begin
						held_ids[held] = id;
						r.status = sidr_pkg::STAT_OK;
						r.found_position = held[3:0];
						r.found_id = 8'(id);
						held++;
					end
				end
				sidr_pkg::CMD_DEL: begin
					if (k >= 0) begin
						r.status = sidr_pkg::STAT_OK;
						r.found_position = k[3:0];
						r.found_id = 8'(id);
						for (int j = k; j < held - 1; j++)
							held_ids[j] = held_ids[j+1];
						held--;
					end
				end
				sidr_pkg::CMD_FIND: begin
					if (k >= 0) begin
						r.status = sidr_pkg::STAT_OK;
						r.found_position = k[3:0];
						r.found_id = 8'(id);
					end
				end
				default: begin
					if (int'(c.position) < held) begin
						r.status = sidr_pkg::STAT_OK;
						r.found_position = c.position;
						r.found_id = 8'(held_ids[c.position]);
					end
				end
			endcase
			r.entry_count = held[4:0];
			return r;
		endfunction

		function void note_command(sidr_pkg::svc_in_t c);
			pending_answers.push_back(registry_answer(c));
		endfunction

		function void check_response(sidr_pkg::svc_out_t got);
			sidr_pkg::svc_out_t want;
			if (pending_answers.size() == 0) begin
				failures++;
				if (failures <= 10)
					$display({"response with none pending: ",
						"status %0d pos %0d id %02h count %0d"},
						got.status, got.found_position, got.found_id, got.entry_count);
				return;
			end
			want = pending_answers.pop_front();
			if (got.status != want.status || got.found_position != want.found_position ||
					got.found_id != want.found_id || got.entry_count != want.entry_count) begin
				failures++;
				if (failures <= 10)
					$display({"mismatch: expected status %0d pos %0d id %02h count %0d, ",
						"got status %0d pos %0d id %02h count %0d"},
						want.status, want.found_position, want.found_id, want.entry_count,
						got.status, got.found_position, got.found_id, got.entry_count);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cmd_valid = 1'b0;
	logic cmd_stall;
	sidr_pkg::svc_in_t cmd = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	sidr_pkg::svc_out_t rsp;

	registry_tracker tracker;
	bit idling = 1'b1;
	int unsigned cycle_count = 0;
	int unsigned stall_len;
	logic [7:0] id_pool [POOL_SIZE];

	service_id_registry_unit u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd(cmd),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// input beats are noted before responses are checked
	always @(posedge clk) begin
		if (arst_n && cmd_valid && !cmd_stall)
			tracker.note_command(cmd);
		if (arst_n && rsp_valid && !rsp_stall)
			tracker.check_response(rsp);
	end

	always begin
		@(posedge clk);
		if (idling && $urandom_range(0, 99) < 20) begin
			stall_len = $urandom_range(1, 10);
			rsp_stall <= 1'b1;
			repeat (stall_len) @(posedge clk);
			rsp_stall <= 1'b0;
		end
	end

	task automatic send_beat(input sidr_pkg::svc_in_t beat);
		int unsigned gap;
		gap = 0;
		if (idling && $urandom_range(0, 99) < 25)
			gap = $urandom_range(1, 10);
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd <= beat;
		@(posedge clk);
		while (cmd_stall) @(posedge clk);
	endtask

	task automatic send_command(input logic [1:0] op, input logic [7:0] id,
			input logic [3:0] pos);
		sidr_pkg::svc_in_t beat;
		beat.command = op;
		beat.sid = id;
		beat.position = pos;
		send_beat(beat);
	endtask

	function automatic sidr_pkg::svc_in_t random_command(mix_t mix);
		sidr_pkg::svc_in_t beat;
		int unsigned r;
		int unsigned add_lim;
		int unsigned del_lim;
		int unsigned find_lim;
		case (mix)
			MIX_FILL: begin add_lim = 55; del_lim = 65; find_lim = 82; end
			MIX_DRAIN: begin add_lim = 12; del_lim = 62; find_lim = 80; end
			default: begin add_lim = 30; del_lim = 55; find_lim = 78; end
		endcase
		r = $urandom_range(0, 99);
		if (r < add_lim)
			beat.command = sidr_pkg::CMD_ADD;
		else if (r < del_lim)
			beat.command = sidr_pkg::CMD_DEL;
		else if (r < find_lim)
			beat.command = sidr_pkg::CMD_FIND;
		else
			beat.command = sidr_pkg::CMD_GET;
		// mostly a small set of ids so duplicates and hits are common
		if ($urandom_range(0, 99) < 80)
			beat.sid = id_pool[$urandom_range(0, POOL_SIZE - 1)];
		else
			beat.sid = 8'($urandom_range(0, 255));
		beat.position = 4'($urandom_range(0, 15));
		return beat;
	endfunction

	initial begin
		logic [7:0] fill_ids [16];
		mix_t mix;
		tracker = new();
		fill_ids = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'h55, 8'hAA, 8'h7F, 8'hFE,
			8'h10, 8'h20, 8'h33, 8'hCC, 8'h0F, 8'hF0, 8'h42, 8'h99};
		id_pool[0] = 8'h00;
		id_pool[1] = 8'hFF;
		for (int i = 2; i < POOL_SIZE; i++)
			id_pool[i] = 8'($urandom_range(0, 255));
		mix = MIX_EVEN;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// fill to capacity, then the full, duplicate and absent cases
		for (int i = 0; i < 16; i++)
			send_command(sidr_pkg::CMD_ADD, fill_ids[i], 4'd0);
		send_command(sidr_pkg::CMD_ADD, 8'hFF, 4'd15);
		send_command(sidr_pkg::CMD_ADD, 8'h5A, 4'd0);
		send_command(sidr_pkg::CMD_GET, 8'h00, 4'd15);
		send_command(sidr_pkg::CMD_GET, 8'hFF, 4'd0);
		send_command(sidr_pkg::CMD_FIND, 8'hFF, 4'd0);
		send_command(sidr_pkg::CMD_DEL, 8'h00, 4'd0);
		send_command(sidr_pkg::CMD_DEL, 8'h00, 4'd0);
		send_command(sidr_pkg::CMD_GET, 8'h00, 4'd15);
		send_command(sidr_pkg::CMD_ADD, 8'hFF, 4'd0);

		for (int i = 0; i < RANDOM_COUNT; i++) begin
			if (i % 50 == 0) begin
				mix = mix_t'($urandom_range(0, 2));
				idling = (DIRECTED_COUNT + i < QUIET_FROM) && ($urandom_range(0, 3) != 0);
			end
			send_beat(random_command(mix));
		end
		cmd_valid <= 1'b0;

		while (tracker.pending_answers.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (tracker.failures == 0 && tracker.pending_answers.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
